@@ src/dpd_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Dictionary pattern decoder package
// Shared payload types, codes and controller/datapath interface structs.
// ---------------------------------------------------------------------------
package dpd_pkg;

    // Input item opcodes.
    localparam logic [1:0] OP_LOAD_LEN  = 2'd0;
    localparam logic [1:0] OP_LOAD_WORD = 2'd1;
    localparam logic [1:0] OP_STREAM    = 2'd2;

    // Fixed geometry of a dictionary entry.
    localparam int WORD_IDX_W = 5;
    localparam int BYTE_W     = 8;
    localparam int TOTAL_W    = 24;

    // Stream parser mode.
    typedef enum logic [1:0] {
        MODE_IDLE      = 2'd0,
        MODE_INDEX_LOW = 2'd1,
        MODE_LITERAL   = 2'd2
    } mode_t;

    // Input beat payload.
    typedef struct packed {
        logic [1:0]  opcode;
        logic [9:0]  entry_index;
        logic [4:0]  word_index;
        logic [63:0] load_value;
        logic [7:0]  stream_byte;
    } in_item_t;

    // Result beat payload.
    typedef struct packed {
        logic [63:0] out_bytes;
        logic [3:0]  out_count;
        logic        last;
        logic        end_of_block;
        logic [23:0] total_length;
        logic        bad_reference;
    } out_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic wr_len;
        logic wr_word;
        logic header;
        logic emit_eob;
        logic emit_lit;
        logic emit_bad;
        logic rd_len;
        logic take_len;
        logic emit_word;
    } dpd_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] opcode;
        mode_t      mode;
        logic       hdr_zero;
        logic       ref_bad;
        logic       len_zero;
        logic       word_last;
        logic       out_free;
    } dpd_sts_t;

endpackage

@@ src/dpd_controller.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Dictionary pattern decoder controller
// Sequences one input beat at a time through decode, length read and copy.
// ---------------------------------------------------------------------------
module dpd_controller (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  dpd_pkg::dpd_sts_t sts,
    output dpd_pkg::dpd_cmd_t cmd
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_DECODE = 4'b0010,
        ST_LEN    = 4'b0100,
        ST_COPY   = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Input is taken only while no item is in flight.
    assign s_ready = (state_reg == ST_IDLE);

    // Next state and command decode.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE: begin
                state_next = ST_IDLE;
                unique case (sts.opcode)
                    dpd_pkg::OP_LOAD_LEN:  cmd.wr_len  = 1'b1;
                    dpd_pkg::OP_LOAD_WORD: cmd.wr_word = 1'b1;
                    dpd_pkg::OP_STREAM: begin
                        unique case (sts.mode)
                            dpd_pkg::MODE_IDLE: begin
                                if (!sts.hdr_zero) begin
                                    cmd.header = 1'b1;
                                end else if (sts.out_free) begin
                                    cmd.emit_eob = 1'b1;
                                end else begin
                                    state_next = ST_DECODE;
                                end
                            end
                            dpd_pkg::MODE_LITERAL: begin
                                if (sts.out_free) begin
                                    cmd.emit_lit = 1'b1;
                                end else begin
                                    state_next = ST_DECODE;
                                end
                            end
                            dpd_pkg::MODE_INDEX_LOW: begin
                                if (!sts.ref_bad) begin
                                    cmd.rd_len = 1'b1;
                                    state_next = ST_LEN;
                                end else if (sts.out_free) begin
                                    cmd.emit_bad = 1'b1;
                                end else begin
                                    state_next = ST_DECODE;
                                end
                            end
                            default: state_next = ST_IDLE;
                        endcase
                    end
                    default: state_next = ST_IDLE;
                endcase
            end
            ST_LEN: begin
                // Length is back from the table; an empty entry gives nothing.
                cmd.take_len = 1'b1;
                state_next   = sts.len_zero ? ST_IDLE : ST_COPY;
            end
            ST_COPY: begin
                if (sts.out_free) begin
                    cmd.emit_word = 1'b1;
                    if (sts.word_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

@@ src/dpd_datapath.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Dictionary pattern decoder datapath
// Dictionary memories, parser state, running total and the output register.
// ---------------------------------------------------------------------------
module dpd_datapath #(
    parameter int DICT_ENTRIES    = 1024,
    parameter int MAX_ENTRY_BYTES = 255
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  dpd_pkg::in_item_t  s_data,
    input  dpd_pkg::dpd_cmd_t  cmd,
    output dpd_pkg::dpd_sts_t  sts,
    output logic               m_valid,
    input  logic               m_ready,
    output dpd_pkg::out_item_t m_data
);

    localparam int IDX_W   = (DICT_ENTRIES > 1) ? $clog2(DICT_ENTRIES) : 1;
    localparam int WADDR_W = IDX_W + dpd_pkg::WORD_IDX_W;
    localparam int WDEPTH  = DICT_ENTRIES * (2 ** dpd_pkg::WORD_IDX_W);
    localparam logic [15:0] ENTRIES_16 = 16'(DICT_ENTRIES);
    localparam logic [7:0]  LEN_MAX    = 8'(MAX_ENTRY_BYTES);
    localparam logic [23:0] TOTAL_MAX  = '1;

    // Dictionary storage.
    logic [7:0]  len_mem  [DICT_ENTRIES];
    logic [63:0] word_mem [WDEPTH];

    dpd_pkg::in_item_t  in_reg;
    dpd_pkg::mode_t     mode_reg, mode_next;
    logic [6:0]         hi_bits_reg, hi_bits_next;
    logic [6:0]         lit_rem_reg, lit_rem_next;
    logic [23:0]        count_reg, count_next;
    logic [IDX_W-1:0]   entry_reg;
    logic [4:0]         word_reg, word_next;
    logic [7:0]         rem_bytes_reg, rem_bytes_next;
    logic [7:0]         len_rdata_reg;
    logic [63:0]        word_rdata_reg;
    logic               m_valid_reg, m_valid_next;
    dpd_pkg::out_item_t m_data_reg, m_data_next;

    logic [15:0]        load_idx_ext;
    logic [15:0]        ref_id_ext;
    logic               load_in_range;
    logic [7:0]         load_len_sat;
    logic [7:0]         addend;
    logic [24:0]        sum;
    logic [23:0]        sum_sat;
    logic [3:0]         word_cnt;
    logic [63:0]        word_mask;
    logic               word_last;
    logic               word_rd;
    logic [WADDR_W-1:0] word_raddr;
    logic               out_free;

    // Address and range decode of the held beat.
    assign load_idx_ext  = {6'd0, in_reg.entry_index};
    assign ref_id_ext    = {1'b0, hi_bits_reg, in_reg.stream_byte};
    assign load_in_range = (load_idx_ext < ENTRIES_16);
    assign load_len_sat  = (in_reg.load_value[7:0] > LEN_MAX) ? LEN_MAX
                                                              : in_reg.load_value[7:0];

    // Saturating update of the running total.
    assign addend  = cmd.take_len ? len_rdata_reg : 8'd1;
    assign sum     = {1'b0, count_reg} + {17'd0, addend};
    assign sum_sat = sum[24] ? TOTAL_MAX : sum[23:0];

    // Byte count and mask of the current copy word.
    assign word_last = (rem_bytes_reg <= 8'd8);
    assign word_cnt  = word_last ? rem_bytes_reg[3:0] : 4'd8;
    assign word_mask = (word_cnt == 4'd8) ? {64{1'b1}}
                     : ~({64{1'b1}} << {word_cnt[2:0], 3'b000});

    // Word reads: first word on length arrival, next word on each emit but the last.
    assign word_rd    = cmd.take_len | (cmd.emit_word & ~word_last);
    assign word_raddr = cmd.take_len ? {entry_reg, 5'd0} : {entry_reg, word_reg + 5'd1};

    assign out_free = ~m_valid_reg | m_ready;

    // Status toward the controller.
    always_comb begin
        sts.opcode    = in_reg.opcode;
        sts.mode      = mode_reg;
        sts.hdr_zero  = (in_reg.stream_byte == 8'd0);
        sts.ref_bad   = (ref_id_ext >= ENTRIES_16);
        sts.len_zero  = (len_rdata_reg == 8'd0);
        sts.word_last = word_last;
        sts.out_free  = out_free;
    end

    // Parser state, total and output beat.
    always_comb begin
        mode_next      = mode_reg;
        hi_bits_next   = hi_bits_reg;
        lit_rem_next   = lit_rem_reg;
        count_next     = count_reg;
        word_next      = word_reg;
        rem_bytes_next = rem_bytes_reg;
        m_data_next    = m_data_reg;
        m_valid_next   = m_valid_reg & ~m_ready;

        if (cmd.header) begin
            if (in_reg.stream_byte[7]) begin
                hi_bits_next = in_reg.stream_byte[6:0];
                mode_next    = dpd_pkg::MODE_INDEX_LOW;
            end else begin
                lit_rem_next = in_reg.stream_byte[6:0];
                mode_next    = dpd_pkg::MODE_LITERAL;
            end
        end

        if (cmd.rd_len) begin
            mode_next = dpd_pkg::MODE_IDLE;
        end

        if (cmd.take_len) begin
            count_next     = sum_sat;
            rem_bytes_next = len_rdata_reg;
            word_next      = 5'd0;
        end

        if (cmd.emit_eob) begin
            m_valid_next              = 1'b1;
            m_data_next               = '0;
            m_data_next.end_of_block  = 1'b1;
            m_data_next.last          = 1'b1;
            m_data_next.total_length  = count_reg;
            count_next                = '0;
        end

        if (cmd.emit_lit) begin
            m_valid_next             = 1'b1;
            m_data_next              = '0;
            m_data_next.out_bytes    = {56'd0, in_reg.stream_byte};
            m_data_next.out_count    = 4'd1;
            m_data_next.last         = 1'b1;
            m_data_next.total_length = sum_sat;
            count_next               = sum_sat;
            lit_rem_next             = lit_rem_reg - 7'd1;
            if (lit_rem_reg == 7'd1) begin
                mode_next = dpd_pkg::MODE_IDLE;
            end
        end

        if (cmd.emit_bad) begin
            m_valid_next              = 1'b1;
            m_data_next               = '0;
            m_data_next.bad_reference = 1'b1;
            m_data_next.last          = 1'b1;
            m_data_next.total_length  = count_reg;
            mode_next                 = dpd_pkg::MODE_IDLE;
        end

        if (cmd.emit_word) begin
            m_valid_next             = 1'b1;
            m_data_next              = '0;
            m_data_next.out_bytes    = word_rdata_reg & word_mask;
            m_data_next.out_count    = word_cnt;
            m_data_next.last         = word_last;
            m_data_next.total_length = count_reg;
            rem_bytes_next           = rem_bytes_reg - 8'd8;
            word_next                = word_reg + 5'd1;
        end
    end

    // Control and state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= dpd_pkg::MODE_IDLE;
            hi_bits_reg <= '0;
            lit_rem_reg <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            mode_reg    <= mode_next;
            hi_bits_reg <= hi_bits_next;
            lit_rem_reg <= lit_rem_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            in_reg <= s_data;
        end
        if (cmd.rd_len) begin
            entry_reg <= ref_id_ext[IDX_W-1:0];
        end
        word_reg      <= word_next;
        rem_bytes_reg <= rem_bytes_next;
        m_data_reg    <= m_data_next;
    end

    // Entry length table.
    always_ff @(posedge aclk) begin
        if (cmd.wr_len && load_in_range) begin
            len_mem[load_idx_ext[IDX_W-1:0]] <= load_len_sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd_len) begin
            len_rdata_reg <= len_mem[ref_id_ext[IDX_W-1:0]];
        end
    end

    // Entry word table.
    always_ff @(posedge aclk) begin
        if (cmd.wr_word && load_in_range) begin
            word_mem[{load_idx_ext[IDX_W-1:0], in_reg.word_index}] <= in_reg.load_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (word_rd) begin
            word_rdata_reg <= word_mem[word_raddr];
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

@@ src/dictionary_pattern_decoder.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Dictionary pattern decoder
// Expands dictionary references and literal runs of a byte stream into
// beats of up to eight bytes, with a saturating per-block total.
// ---------------------------------------------------------------------------
//  Channel | Direction | Handshake          | Payload
//  s_      | in        | s_valid / s_ready  | dpd_pkg::in_item_t
//  m_      | out       | m_valid / m_ready  | dpd_pkg::out_item_t
//
// One input beat is in flight at a time. A load beat, header byte, literal
// byte, terminator or bad reference passes through capture and decode; a
// valid reference also reads the entry length, then emits one beat per
// 8-byte word of the entry, paced by the single read port of the word table.
// The output register holds a beat while m_ready is low; only a beat that
// needs to emit waits for it. Reset is synchronous, active low, and needs
// no clearing pass: the dictionary must be loaded before it is referenced.
// ---------------------------------------------------------------------------
module dictionary_pattern_decoder #(
    parameter int DICT_ENTRIES    = 1024,
    parameter int MAX_ENTRY_BYTES = 255
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  dpd_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output dpd_pkg::out_item_t m_data
);

    dpd_pkg::dpd_cmd_t cmd;
    dpd_pkg::dpd_sts_t sts;

    // Sequencer.
    dpd_controller u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Tables, parser state and output register.
    dpd_datapath #(
        .DICT_ENTRIES    (DICT_ENTRIES),
        .MAX_ENTRY_BYTES (MAX_ENTRY_BYTES)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .sts     (sts),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
